/* rtl/diof_pkg.sv */
// Shared types and constants for the direct form I IIR filter core.
// No dependencies; imported by every module of the block.
package diof_pkg;

    // Sample and gain formats (fixed by the stream and register formats)
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 18;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // Defaults for the top level parameters
    localparam int FF_TAPS_DEF        = 4;
    localparam int FB_TAPS_DEF        = 3;
    localparam int GAIN_FRAC_BITS_DEF = 15;

    // Reset value of the current-sample gain (unity in Q2.15)
    localparam logic signed [GAIN_W-1:0] GAIN_RESET_ONE = 18'sd32768;

    // Request kinds carried in tuser
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Step control from the handshake logic to the datapath
    typedef struct packed {
        logic fire;   // the item in the input register is consumed this cycle
        logic clear;  // that item is a clear request
    } step_ctl_t;

endpackage

/* rtl/diof_gain_regs.sv */
// Gain register file: feed-forward and feedback gains, written by index.
// Depends on diof_pkg.
module diof_gain_regs #(
    parameter int FF_TAPS = diof_pkg::FF_TAPS_DEF,
    parameter int FB_TAPS = diof_pkg::FB_TAPS_DEF,
    parameter int IDX_W   = $clog2(FF_TAPS + FB_TAPS)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [IDX_W-1:0]                       cfg_index,
    input  logic [diof_pkg::GAIN_W-1:0]            cfg_data,
    output logic signed [diof_pkg::GAIN_W-1:0]     ff_gain [FF_TAPS],
    output logic signed [diof_pkg::GAIN_W-1:0]     fb_gain [FB_TAPS]
);
    import diof_pkg::*;

    logic signed [GAIN_W-1:0] ff_gain_reg [FF_TAPS];
    logic signed [GAIN_W-1:0] fb_gain_reg [FB_TAPS];

    // Register writes; indexes past the last gain are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FF_TAPS; k++)
            begin
                ff_gain_reg[k] <= (k == 0) ? GAIN_RESET_ONE : '0;
            end
            for (int k = 0; k < FB_TAPS; k++)
            begin
                fb_gain_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int k = 0; k < FF_TAPS; k++)
            begin
                if (cfg_index == IDX_W'(k))
                begin
                    ff_gain_reg[k] <= $signed(cfg_data);
                end
            end
            for (int k = 0; k < FB_TAPS; k++)
            begin
                if (cfg_index == IDX_W'(FF_TAPS + k))
                begin
                    fb_gain_reg[k] <= $signed(cfg_data);
                end
            end
        end
    end

    assign ff_gain = ff_gain_reg;
    assign fb_gain = fb_gain_reg;

endmodule

/* rtl/diof_datapath.sv */
// Filter datapath: input/output histories, parallel products, sum,
// rounding and saturation. Depends on diof_pkg.
module diof_datapath #(
    parameter int FF_TAPS        = diof_pkg::FF_TAPS_DEF,
    parameter int FB_TAPS        = diof_pkg::FB_TAPS_DEF,
    parameter int GAIN_FRAC_BITS = diof_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  diof_pkg::step_ctl_t                    ctl,
    input  logic signed [diof_pkg::SAMPLE_W-1:0]   x,
    input  logic signed [diof_pkg::GAIN_W-1:0]     ff_gain [FF_TAPS],
    input  logic signed [diof_pkg::GAIN_W-1:0]     fb_gain [FB_TAPS],
    output logic signed [diof_pkg::SAMPLE_W-1:0]   y
);
    import diof_pkg::*;

    localparam int XH     = (FF_TAPS > 1) ? FF_TAPS - 1 : 1;
    localparam int PROD_W = GAIN_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + $clog2(FF_TAPS + FB_TAPS) + 1;
    localparam logic signed [ACC_W-1:0] RND_HALF =
        ACC_W'(64'sd1 <<< (GAIN_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

    logic signed [SAMPLE_W-1:0] past_in_reg  [XH];
    logic signed [SAMPLE_W-1:0] past_out_reg [FB_TAPS];
    logic signed [PROD_W-1:0]   prod_ff      [FF_TAPS];
    logic signed [PROD_W-1:0]   prod_fb      [FB_TAPS];
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [ACC_W-1:0]    scaled;

    // Products, all in parallel
    always_comb
    begin
        prod_ff[0] = ff_gain[0] * x;
        for (int k = 1; k < FF_TAPS; k++)
        begin
            prod_ff[k] = ff_gain[k] * past_in_reg[k-1];
        end
        for (int k = 0; k < FB_TAPS; k++)
        begin
            prod_fb[k] = fb_gain[k] * past_out_reg[k];
        end
    end

    // Sum, feedback terms subtracted
    always_comb
    begin
        acc = '0;
        for (int k = 0; k < FF_TAPS; k++)
        begin
            acc = acc + ACC_W'(prod_ff[k]);
        end
        for (int k = 0; k < FB_TAPS; k++)
        begin
            acc = acc - ACC_W'(prod_fb[k]);
        end
    end

    // Round half up, drop fraction bits, clamp to sample range
    always_comb
    begin
        rnd    = acc + RND_HALF;
        scaled = rnd >>> GAIN_FRAC_BITS;
        if (scaled > SAT_HI)
        begin
            y = SAMPLE_W'(SAMPLE_MAX);
        end
        else if (scaled < SAT_LO)
        begin
            y = SAMPLE_W'(SAMPLE_MIN);
        end
        else
        begin
            y = scaled[SAMPLE_W-1:0];
        end
    end

    // History shift on a filter request, zeroing on a clear request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < XH; k++)
            begin
                past_in_reg[k] <= '0;
            end
            for (int k = 0; k < FB_TAPS; k++)
            begin
                past_out_reg[k] <= '0;
            end
        end
        else if (ctl.fire)
        begin
            if (ctl.clear)
            begin
                for (int k = 0; k < XH; k++)
                begin
                    past_in_reg[k] <= '0;
                end
                for (int k = 0; k < FB_TAPS; k++)
                begin
                    past_out_reg[k] <= '0;
                end
            end
            else
            begin
                for (int k = XH - 1; k > 0; k--)
                begin
                    past_in_reg[k] <= past_in_reg[k-1];
                end
                past_in_reg[0] <= x;
                for (int k = FB_TAPS - 1; k > 0; k--)
                begin
                    past_out_reg[k] <= past_out_reg[k-1];
                end
                past_out_reg[0] <= y;
            end
        end
    end

endmodule

/* rtl/direct_form_one_iir_filter_core.sv */
// Top level of the direct form I IIR filter: stream handshake, input and
// result registers. Depends on diof_pkg, diof_gain_regs and diof_datapath.
//
// Usage:
//   Requests enter on the s_ channel: s_tdata is the 16-bit signed sample,
//   s_tuser selects filter (0) or clear (1). A filter request yields one
//   16-bit result on the m_ channel; a clear request zeroes both sample
//   histories and yields nothing. Gains are set through cfg_we / cfg_index /
//   cfg_data: indexes 0..FF_TAPS-1 are feed-forward gains, the next FB_TAPS
//   are feedback gains; other indexes are ignored. Write them only while idle.
//   A request is captured in the input register when it is accepted; its
//   result is registered in the output register when that stage moves on.
//   Throughput: one request per cycle while the result channel does not
//   stall. The whole multiply-accumulate, round and saturate is combinational
//   between the two registers, which also closes the output feedback loop.
//   Reset: gains return to unity pass-through, histories to zero, both
//   channels empty. When m_tready is low the result holds; s_tready drops
//   once the input register also holds a filter request.
module direct_form_one_iir_filter_core #(
    parameter int FF_TAPS        = diof_pkg::FF_TAPS_DEF,
    parameter int FB_TAPS        = diof_pkg::FB_TAPS_DEF,
    parameter int GAIN_FRAC_BITS = diof_pkg::GAIN_FRAC_BITS_DEF,
    parameter int IDX_W          = $clog2(FF_TAPS + FB_TAPS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [diof_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    input  logic                            s_tuser,   // [0] cmd
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [diof_pkg::SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
    // gain register writes
    input  logic                            cfg_we,
    input  logic [IDX_W-1:0]                cfg_index,
    input  logic [diof_pkg::GAIN_W-1:0]     cfg_data
);
    import diof_pkg::*;

    logic                       in_valid_reg;
    logic                       in_cmd_reg;
    logic signed [SAMPLE_W-1:0] in_x_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       adv;
    logic                       is_clear;
    step_ctl_t                  ctl;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [GAIN_W-1:0]   ff_gain [FF_TAPS];
    logic signed [GAIN_W-1:0]   fb_gain [FB_TAPS];

    // Gain registers
    diof_gain_regs #(
        .FF_TAPS (FF_TAPS),
        .FB_TAPS (FB_TAPS),
        .IDX_W   (IDX_W)
    ) u_gain_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ff_gain   (ff_gain),
        .fb_gain   (fb_gain)
    );

    // Input stage moves on when it holds a clear, or the result slot frees
    assign is_clear = (in_cmd_reg == CMD_CLEAR);
    assign adv      = in_valid_reg && (is_clear || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign ctl.fire  = adv;
    assign ctl.clear = is_clear;

    // Filter datapath
    diof_datapath #(
        .FF_TAPS        (FF_TAPS),
        .FB_TAPS        (FB_TAPS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .x       (in_x_reg),
        .ff_gain (ff_gain),
        .fb_gain (fb_gain),
        .y       (y)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv && !is_clear)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg <= s_tuser;
            in_x_reg   <= $signed(s_tdata);
        end
        if (adv && !is_clear)
        begin
            out_data_reg <= y;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A filter request always lands a result in the output register
    a_filter_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !is_clear) |=> out_valid_reg)
        else $error("filter request produced no result");

    // A clear request never produces a result of its own
    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && is_clear && (!out_valid_reg || m_tready)) |=> !out_valid_reg)
        else $error("clear request produced a result");

    // A stalled result is never overwritten by a filter request
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && in_valid_reg && !is_clear) |-> !adv)
        else $error("stalled result overwritten");

endmodule

/* dv/direct_form_one_iir_filter_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for direct_form_one_iir_filter_core.
// Depends on diof_pkg and the core RTL; a built-in predictor runs the filter
// arithmetic alongside the block and checks every result sample in order.
module direct_form_one_iir_filter_core_test;

    import diof_pkg::*;

    // Register map of the gain port
    localparam int REG_FF_BASE = 0;
    localparam int REG_FB_BASE = FF_TAPS_DEF;
    localparam int NUM_REGS    = FF_TAPS_DEF + FB_TAPS_DEF;
    localparam int REG_UNUSED  = NUM_REGS;   // beyond the list, write ignored
    localparam int FRAC        = GAIN_FRAC_BITS_DEF;
    localparam int MAX_REPORTS = 100;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;     // [15:0] sample_in
    logic                  s_tuser = 1'b0;   // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;          // [15:0] sample_out
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [GAIN_W-1:0]     cfg_data = '0;

    // Predictor state: gains and sample histories
    logic signed [GAIN_W-1:0]   ff_gain_q [FF_TAPS_DEF];
    logic signed [GAIN_W-1:0]   fb_gain_q [FB_TAPS_DEF];
    logic signed [SAMPLE_W-1:0] x_hist [FF_TAPS_DEF-1];
    logic signed [SAMPLE_W-1:0] y_hist [FB_TAPS_DEF];
    logic signed [SAMPLE_W-1:0] predicted_samples [$];

    // Run control and bookkeeping
    bit idle_on = 1'b1;
    int stall_request = 0;
    int stall_left = 0;
    int errors = 0;
    int n_requests = 0;
    int n_clears = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_settings = 0;

    direct_form_one_iir_filter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Filter arithmetic: exact sum, round half up, saturate
    function automatic logic signed [SAMPLE_W-1:0] filter_next(
        input logic signed [SAMPLE_W-1:0] x);
        longint acc;
        longint y;
        acc = longint'(ff_gain_q[0]) * longint'(x);
        for (int k = 1; k < FF_TAPS_DEF; k++)
            acc += longint'(ff_gain_q[k]) * longint'(x_hist[k-1]);
        for (int k = 0; k < FB_TAPS_DEF; k++)
            acc -= longint'(fb_gain_q[k]) * longint'(y_hist[k]);
        y = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (y > SAMPLE_MAX)
            y = SAMPLE_MAX;
        if (y < SAMPLE_MIN)
            y = SAMPLE_MIN;
        return y[SAMPLE_W-1:0];
    endfunction

    // Result check, gain tracking and prediction, all on pre-edge values
    always @(posedge clk)
    begin : track
        logic signed [SAMPLE_W-1:0] want;
        logic signed [SAMPLE_W-1:0] y;
        if (!rst_n)
        begin
            ff_gain_q[0] = GAIN_RESET_ONE;
            for (int k = 1; k < FF_TAPS_DEF; k++)
                ff_gain_q[k] = '0;
            for (int k = 0; k < FB_TAPS_DEF; k++)
                fb_gain_q[k] = '0;
            for (int k = 0; k < FF_TAPS_DEF - 1; k++)
                x_hist[k] = '0;
            for (int k = 0; k < FB_TAPS_DEF; k++)
                y_hist[k] = '0;
        end
        else
        begin
            // result side
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (predicted_samples.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $error("unexpected result: sample_out %0d", $signed(m_tdata));
                end
                else
                begin
                    want = predicted_samples.pop_front();
                    if ($signed(m_tdata) !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $error("sample_out mismatch: expected %0d, actual %0d",
                                   want, $signed(m_tdata));
                    end
                end
            end
            // gain writes
            if (cfg_we)
            begin
                if (cfg_index < REG_FB_BASE)
                    ff_gain_q[cfg_index - REG_FF_BASE] = cfg_data;
                else if (cfg_index < NUM_REGS)
                    fb_gain_q[cfg_index - REG_FB_BASE] = cfg_data;
            end
            // request side
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_CLEAR)
                begin
                    for (int k = 0; k < FF_TAPS_DEF - 1; k++)
                        x_hist[k] = '0;
                    for (int k = 0; k < FB_TAPS_DEF; k++)
                        y_hist[k] = '0;
                end
                else
                begin
                    y = filter_next($signed(s_tdata));
                    predicted_samples.push_back(y);
                    for (int k = FF_TAPS_DEF - 2; k > 0; k--)
                        x_hist[k] = x_hist[k-1];
                    x_hist[0] = $signed(s_tdata);
                    for (int k = FB_TAPS_DEF - 1; k > 0; k--)
                        y_hist[k] = y_hist[k-1];
                    y_hist[0] = y;
                end
            end
        end
    end

    // Result ready: random stalls, plus a counted hold-off on request
    always @(posedge clk)
    begin
        if (stall_request > 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(99) < 15)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // Offer one request and wait until it is taken
    task automatic send_request(input logic cmd, input logic [SAMPLE_W-1:0] sample);
        // an idle gap before about one request in fourteen while idling is on
        if (idle_on && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= sample;
        n_requests++;
        if (cmd == CMD_CLEAR)
            n_clears++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering, let all results out, then cover the clear latency
    task automatic wait_idle;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (predicted_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gain(input int index, input logic [GAIN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index[2:0];
        cfg_data  <= value;
        n_writes++;
        @(posedge clk);
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] ff [FF_TAPS_DEF],
                              input logic [GAIN_W-1:0] fb [FB_TAPS_DEF]);
        wait_idle();
        for (int k = 0; k < FF_TAPS_DEF; k++)
            write_gain(REG_FF_BASE + k, ff[k]);
        for (int k = 0; k < FB_TAPS_DEF; k++)
            write_gain(REG_FB_BASE + k, fb[k]);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample;
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain(input int span);
        return 18'($urandom_range(0, 2 * span) - span);
    endfunction

    // Unity pass-through after reset, extremes of the sample, clears
    task automatic test_reset_passthrough;
        send_request(CMD_FILTER, 16'h7FFF);
        send_request(CMD_FILTER, 16'h8000);
        send_request(CMD_FILTER, 16'h0000);
        send_request(CMD_FILTER, 16'h0001);
        send_request(CMD_FILTER, 16'hFFFF);
        send_request(CMD_FILTER, 16'h5555);
        send_request(CMD_CLEAR,  16'hAAAA);
        send_request(CMD_FILTER, 16'hAAAA);
        send_request(CMD_CLEAR,  16'h7FFF);
    endtask

    // Gains at both extremes: saturation both ways, unused index ignored
    task automatic test_gain_extremes;
        logic [GAIN_W-1:0] ff [FF_TAPS_DEF];
        logic [GAIN_W-1:0] fb [FB_TAPS_DEF];
        foreach (ff[k]) ff[k] = 18'h1FFFF;
        foreach (fb[k]) fb[k] = 18'h00000;
        load_gains(ff, fb);
        send_request(CMD_FILTER, 16'h7FFF);
        send_request(CMD_FILTER, 16'h8000);
        send_request(CMD_FILTER, 16'h8000);
        foreach (ff[k]) ff[k] = 18'h20000;
        foreach (fb[k]) fb[k] = 18'h1FFFF;
        load_gains(ff, fb);
        send_request(CMD_FILTER, 16'h7FFF);
        send_request(CMD_FILTER, 16'h0001);
        send_request(CMD_FILTER, 16'h8000);
        foreach (fb[k]) fb[k] = 18'h20000;
        load_gains(ff, fb);
        // a write past the last register must change nothing
        write_gain(REG_UNUSED, 18'h2AAAA);
        cfg_we <= 1'b0;
        send_request(CMD_FILTER, 16'h0100);
        send_request(CMD_CLEAR,  16'h0000);
        send_request(CMD_FILTER, 16'hFF00);
    endtask

    // Half gain: exact halves round toward plus infinity
    task automatic test_rounding;
        logic [GAIN_W-1:0] ff [FF_TAPS_DEF];
        logic [GAIN_W-1:0] fb [FB_TAPS_DEF];
        foreach (ff[k]) ff[k] = '0;
        foreach (fb[k]) fb[k] = '0;
        ff[0] = 18'sd16384;
        load_gains(ff, fb);
        send_request(CMD_FILTER, 16'h0001);
        send_request(CMD_FILTER, 16'hFFFF);
        send_request(CMD_FILTER, 16'h0003);
        send_request(CMD_FILTER, 16'hFFFD);
    endtask

    // Result side held off long enough that the block stalls its input
    task automatic test_backpressure;
        idle_on = 1'b0;
        wait_idle();
        stall_request = 40;
        repeat (30) send_request(CMD_FILTER, rand_sample());
        idle_on = 1'b1;
    endtask

    // Random settings, each followed by a stream of random requests
    task automatic test_random_settings(input int phases, input int per_phase);
        logic [GAIN_W-1:0] ff [FF_TAPS_DEF];
        logic [GAIN_W-1:0] fb [FB_TAPS_DEF];
        for (int p = 0; p < phases; p++)
        begin
            case (p % 4)
                0:
                begin
                    // stable recursive filter
                    foreach (ff[k]) ff[k] = rand_gain(20000);
                    foreach (fb[k]) fb[k] = rand_gain(8000);
                end
                1:
                begin
                    // any gains at all, mostly saturating
                    foreach (ff[k]) ff[k] = 18'($urandom_range(0, 262143));
                    foreach (fb[k]) fb[k] = 18'($urandom_range(0, 262143));
                end
                2:
                begin
                    // pure FIR
                    foreach (ff[k]) ff[k] = rand_gain(40000);
                    foreach (fb[k]) fb[k] = '0;
                end
                default:
                begin
                    // moving average over all taps
                    foreach (ff[k]) ff[k] = 18'sd8192;
                    foreach (fb[k]) fb[k] = '0;
                end
            endcase
            load_gains(ff, fb);
            if ($urandom_range(1) == 1)
            begin
                write_gain(REG_UNUSED, 18'($urandom_range(0, 262143)));
                cfg_we <= 1'b0;
            end
            // one phase runs with no idling on either side
            idle_on = (p != 5);
            for (int i = 0; i < per_phase; i++)
                if ($urandom_range(99) < 3)
                    send_request(CMD_CLEAR, 16'($urandom_range(0, 65535)));
                else
                    send_request(CMD_FILTER, rand_sample());
        end
        idle_on = 1'b1;
    endtask

    // Sequence of tests and final verdict
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_passthrough();
        test_gain_extremes();
        test_rounding();
        test_backpressure();
        test_random_settings(11, 128);
        wait_idle();
        repeat (8) @(posedge clk);
        if (predicted_samples.size() != 0)
        begin
            errors += predicted_samples.size();
            $error("%0d expected results never arrived", predicted_samples.size());
        end
        $display("Run covered %0d requests (%0d clears) and %0d results", n_requests,
                 n_clears, n_results);
        $display("over %0d gain settings with %0d register writes", n_settings, n_writes);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* direct_form_one_iir_filter_core.f */
rtl/diof_pkg.sv
rtl/diof_gain_regs.sv
rtl/diof_datapath.sv
rtl/direct_form_one_iir_filter_core.sv
dv/direct_form_one_iir_filter_core_test.sv
